>>> sv/bhs_pkg.sv
// bhs_pkg: shared types and constants for the bucketed hash set
// opcode and status codes, back-end state encoding, queue sizing
// no dependencies
`default_nettype none

package bhs_pkg;

    localparam int KEY_W = 64;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW = 1;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_MISS      = 3'd0,
        ST_HIT       = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic    present;
        status_t status;
    } result_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_READ,
        BK_CHECK
    } back_state_t;

endpackage

`default_nettype wire

>>> sv/bhs_ram.sv
// bhs_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module bhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/bhs_front.sv
// bhs_front: request intake, picks the bucket for each key and pushes it to the queue
// depends on bhs_pkg
`default_nettype none

module bhs_front #(
    parameter int BUCKETS = 256
) (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bhs_pkg::KEY_W-1:0]         s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              clearing,
    input  wire logic                              q_ready,
    output logic                                   q_push,
    output logic [$clog2(BUCKETS)+bhs_pkg::KEY_W:0] q_wdata
);
    import bhs_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int PW = 33 + BW;

    logic [PW-1:0] prod;
    logic [BW-1:0] bucket;

    // bucket = (key_hi * BUCKETS) >> 32, always below BUCKETS
    assign prod   = PW'(s_tdata[63:32]) * PW'(BUCKETS);
    assign bucket = prod[32 +: BW];

    assign s_tready = q_ready && !clearing;
    assign q_push   = s_tvalid && s_tready;
    assign q_wdata  = {bucket, s_tdata, s_tuser};

endmodule

`default_nettype wire

>>> sv/bhs_queue.sv
// bhs_queue: short request queue between intake and execution
// depends on bhs_pkg
`default_nettype none

module bhs_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  ready,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] rdata
);
    import bhs_pkg::*;

    logic [WIDTH-1:0] entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]    count_reg, count_next;

    assign ready = count_reg != (Q_AW+1)'(Q_DEPTH);
    assign valid = count_reg != '0;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> sv/bhs_back.sv
// bhs_back: executes requests against the bucket ram and holds the result register
// read a whole bucket row, compare all slots, write back key and fill count
// depends on bhs_pkg and bhs_ram
`default_nettype none

module bhs_back #(
    parameter int BUCKETS          = 256,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   q_valid,
    output logic                                        q_pop,
    input  wire logic [$clog2(BUCKETS)+bhs_pkg::KEY_W:0] q_rdata,
    output logic                                        clearing,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output bhs_pkg::result_t                            m_result
);
    import bhs_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int CW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int ROW_W = CW + KEY_W * SLOTS_PER_BUCKET;

    back_state_t state_reg, state_next;
    logic [BW-1:0]    clr_cnt_reg;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BW-1:0]    bucket_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;

    logic             ram_we, ram_re;
    logic [BW-1:0]    ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, rd_row, new_row;
    logic [CW-1:0]    rd_fill;
    logic [SLOTS_PER_BUCKET-1:0] match;
    logic             hit, full, do_insert, out_load;
    result_t          res;

    // row layout: fill count in the low bits, then slot 0, slot 1, ...
    bhs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_row)
    );

    assign rd_fill = rd_row[CW-1:0];

    // only slots below the fill count take part
    always_comb begin
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
            match[i] = (CW'(i) < rd_fill) && (rd_row[CW + KEY_W*i +: KEY_W] == key_reg);
        end
    end

    assign hit  = |match;
    assign full = rd_fill >= CW'(SLOTS_PER_BUCKET);

    always_comb begin
        res.present = hit;
        do_insert   = 1'b0;
        if (op_reg == OP_LOOKUP) begin
            res.status = hit ? ST_HIT : ST_MISS;
        end else if (hit) begin
            res.status = ST_DUPLICATE;
        end else if (full) begin
            res.status = ST_FULL;
        end else begin
            res.status = ST_INSERTED;
            do_insert  = 1'b1;
        end
    end

    always_comb begin
        new_row = rd_row;
        new_row[CW-1:0] = rd_fill + 1'b1;
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
            if (CW'(i) == rd_fill) begin
                new_row[CW + KEY_W*i +: KEY_W] = key_reg;
            end
        end
    end

    assign out_load = (state_reg == BK_CHECK) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: begin
                if (clr_cnt_reg == BW'(BUCKETS - 1)) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                if (q_valid) begin
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK: begin
                if (out_load) begin
                    state_next = BK_READ;
                end
            end
            default: state_next = BK_CLEAR;
        endcase
    end

    always_comb begin
        clearing  = 1'b0;
        q_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = bucket_reg;
        ram_wdata = new_row;
        ram_raddr = q_rdata[KEY_W+1 +: BW];
        unique case (state_reg)
            BK_CLEAR: begin
                clearing  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            BK_READ: begin
                q_pop  = q_valid;
                ram_re = q_valid;
            end
            BK_CHECK: begin
                ram_we = out_load && do_insert;
            end
            default: clearing = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg     <= op_t'(q_rdata[0]);
            key_reg    <= q_rdata[KEY_W:1];
            bucket_reg <= q_rdata[KEY_W+1 +: BW];
        end
        if (out_load) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_res_reg;

    // the single ram port pair is never read and written in one cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("bucket ram read and write in the same cycle");

    // no request leaves the queue while the clearing pass runs
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !q_pop)
        else $error("request taken during clearing pass");

    // a stored fill count never passes the bucket size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CHECK) |-> (rd_fill <= CW'(SLOTS_PER_BUCKET)))
        else $error("bucket fill count out of range");

    // a write-back happens exactly when an insert result is produced
    a_write_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (ram_we == (res.status == ST_INSERTED)))
        else $error("write-back does not match result status");

    // a stalled result is not overwritten
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_result))
        else $error("pending result changed while stalled");

endmodule

`default_nettype wire

>>> sv/bucketed_hash_set.sv
// channel  | dir | ports                     | contents
// request  | in  | s_tvalid s_tready s_tdata | s_tdata key[63:0], s_tuser opcode
//          |     | s_tuser                   |
// result   | out | m_tvalid m_tready m_tdata | m_tdata present[0], status[3:1]
//
// each request passes through two states in the execution stage: the
// registered read of the whole bucket row, then compare and write-back.
// after reset every row of the bucket ram is swept to zero the fill
// counts; s_tready stays low during the sweep.
// a 2-entry queue separates intake from execution, and the result register
// lets the next request be read while a finished result waits on m_tready.
//
// top level: bucketed hash set, depends on bhs_pkg, bhs_front, bhs_queue, bhs_back
`default_nettype none

module bucketed_hash_set #(
    parameter int BUCKETS          = 256,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[63:0]
    input  wire logic [0:0]  s_tuser,   // opcode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // present[0], status[3:1], zero[7:4]
);
    import bhs_pkg::*;

    localparam int BW   = $clog2(BUCKETS);
    localparam int QW   = BW + KEY_W + 1;

    logic          q_push, q_ready, q_pop, q_valid, clearing;
    logic [QW-1:0] q_wdata, q_rdata;
    result_t       result;

    bhs_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser[0]),
        .clearing (clearing),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    bhs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    bhs_back #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_rdata  (q_rdata),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {4'b0000, result.status, result.present};

endmodule

`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for bucketed_hash_set, lookups and inserts against a behavioral copy
// of the bucket table, random backpressure on both channels; depends on bhs_pkg and the rtl
`default_nettype none

module tb;
    import bhs_pkg::*;

    localparam int NUM_BUCKETS = 256;
    localparam int BUCKET_SLOTS = 8;
    // clear sweep plus ~1700 requests, each with the worst idle gap and result stall, taken several times
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct {
        logic [63:0] key;
        op_t         op;
        result_t     outcome;
    } pending_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // behavioral bucket table
    logic [63:0] key_table [NUM_BUCKETS][BUCKET_SLOTS];
    int          bucket_count [NUM_BUCKETS];

    pending_t    outcome_fifo [$];
    logic [63:0] recent_keys [$];
    logic [7:0]  hot_bucket [8];
    logic [55:0] tail_pool [12];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  idle_en = 1'b1;
    int  sink_stall_left = 0;

    bucketed_hash_set #(
        .BUCKETS(NUM_BUCKETS),
        .SLOTS_PER_BUCKET(BUCKET_SLOTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bucketed_hash_set test failed");
            $finish;
        end
    end

    function automatic result_t predict_outcome(op_t op, logic [63:0] key);
        result_t r;
        logic [7:0] b;
        int fill;
        bit hit;
        b = key[63:56];
        fill = bucket_count[b];
        hit = 1'b0;
        for (int i = 0; i < fill; i++) begin
            if (key_table[b][i] == key)
                hit = 1'b1;
        end
        if (op == OP_LOOKUP) begin
            r.status = hit ? ST_HIT : ST_MISS;
        end else if (hit) begin
            r.status = ST_DUPLICATE;
        end else if (fill >= BUCKET_SLOTS) begin
            r.status = ST_FULL;
        end else begin
            key_table[b][fill] = key;
            bucket_count[b] = fill + 1;
            r.status = ST_INSERTED;
        end
        r.present = hit;
        return r;
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch: %s", what);
    endtask

    // result channel: random stall bursts while idling is enabled
    always @(posedge aclk) begin
        if (idle_en && sink_stall_left > 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 15) == 0) begin
            sink_stall_left <= $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pending_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_fifo.size() == 0) begin
                note_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = outcome_fifo.pop_front();
                if (m_tdata[0] !== want.outcome.present ||
                    m_tdata[3:1] !== want.outcome.status) begin
                    note_mismatch($sformatf(
                        "op %s key %h: expected present %0d status %s, got present %b status %0d",
                        want.op.name(), want.key, want.outcome.present,
                        want.outcome.status.name(), m_tdata[0], m_tdata[3:1]));
                end
            end
        end
    end

    task automatic send_request(op_t op, logic [63:0] key);
        pending_t p;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p.key = key;
        p.op = op;
        p.outcome = predict_outcome(op, key);
        outcome_fifo.push_back(p);
        recent_keys.push_back(key);
        if (recent_keys.size() > 64)
            void'(recent_keys.pop_front());
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (outcome_fifo.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_lookups();
        send_request(OP_LOOKUP, 64'h0);
        send_request(OP_LOOKUP, '1);
        send_request(OP_LOOKUP, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_insert_and_duplicate();
        send_request(OP_INSERT, 64'h0);
        send_request(OP_LOOKUP, 64'h0);
        send_request(OP_INSERT, 64'h0);
        // one bit away from a stored key must miss
        send_request(OP_LOOKUP, 64'h1);
        send_request(OP_LOOKUP, 64'h0080_0000_0000_0000);
    endtask

    task automatic test_full_bucket();
        logic [63:0] k;
        send_request(OP_INSERT, '1);
        for (int i = 1; i < BUCKET_SLOTS; i++) begin
            k = {8'hff, 56'(i) << (i * 7)};
            send_request(OP_INSERT, k);
        end
        // bucket now full: absent key rejected, present key still a duplicate
        send_request(OP_INSERT, 64'hff00_0000_0000_0000);
        send_request(OP_INSERT, '1);
        send_request(OP_LOOKUP, 64'hff00_0000_0000_0000);
        send_request(OP_LOOKUP, '1);
    endtask

    task automatic test_bucket_boundary();
        send_request(OP_INSERT, 64'h00ff_ffff_ffff_ffff);
        send_request(OP_LOOKUP, 64'h0100_0000_0000_0000);
        send_request(OP_INSERT, 64'h0100_0000_0000_0000);
        send_request(OP_LOOKUP, 64'h00ff_ffff_ffff_ffff);
    endtask

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 || recent_keys.size() == 0) begin
            k = {hot_bucket[$urandom_range(0, 7)], tail_pool[$urandom_range(0, 11)]};
        end else if (r < 70) begin
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end else if (r < 80) begin
            // near miss: same bucket most of the time, one bit flipped
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            k[$urandom_range(0, 63)] ^= 1'b1;
        end else begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    task automatic test_random_traffic(int count);
        for (int i = 0; i < 8; i++)
            hot_bucket[i] = 8'($urandom);
        for (int i = 0; i < 12; i++)
            tail_pool[i] = {24'($urandom), $urandom};
        for (int i = 0; i < count; i++)
            send_request($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, pick_key());
    endtask

    initial begin
        for (int b = 0; b < NUM_BUCKETS; b++)
            bucket_count[b] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_lookups();
        test_insert_and_duplicate();
        test_full_bucket();
        test_bucket_boundary();
        wait_for_results();

        test_random_traffic(1300);
        wait_for_results();

        // last stretch runs flat out on both sides
        idle_en = 1'b0;
        test_random_traffic(350);
        wait_for_results();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outcome_fifo.size() == 0) begin
            $display("bucketed_hash_set test passed");
        end else begin
            $display("bucketed_hash_set test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
